/* hw/rtl/histogram_backproject_integral_assert.svh */
// ----------------------------------------------------------------------------
// histogram_backproject_integral_assert.svh
// Assertion macros used by the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef HISTOGRAM_BACKPROJECT_INTEGRAL_ASSERT_SVH
`define HISTOGRAM_BACKPROJECT_INTEGRAL_ASSERT_SVH

// Clocked property, switched off while reset is asserted
`define HBI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that also holds during reset
`define HBI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/hbi_pkg.sv */
// ----------------------------------------------------------------------------
// hbi_pkg
// Types and fixed constants of the histogram back-projection integral block.
// ----------------------------------------------------------------------------
package hbi_pkg;

  // Port and field widths fixed by the stream format
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_DATA_W  = 11;
  localparam int IN_WEIGHT_W = 16;
  localparam int SUM_W       = 36;
  localparam int MASK_W      = 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - SUM_W - MASK_W;
  localparam int ROW_W       = 10;
  localparam int HEIGHT_W    = 11;
  localparam int MAX_HEIGHT  = 1024;

  // Register reset values
  localparam logic [CFG_DATA_W-1:0] RST_FRAME_WIDTH  = 11'd320;
  localparam logic [CFG_DATA_W-1:0] RST_FRAME_HEIGHT = 11'd240;

  // Mask byte values
  localparam logic [MASK_W-1:0] MASK_ON  = 8'd255;
  localparam logic [MASK_W-1:0] MASK_OFF = 8'd0;

  // Input item kind carried on tuser
  typedef enum logic {
    FUNC_WEIGHT = 1'b0,
    FUNC_PIXEL  = 1'b1
  } func_t;

  // Configuration register index
  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // Position flags of a pixel travelling from the front end to the accumulator
  typedef struct packed {
    logic first_col;
    logic first_row;
    logic frame_end;
  } pix_flags_t;

endpackage

/* hw/rtl/hbi_ram.sv */
// ----------------------------------------------------------------------------
// hbi_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module hbi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write, and register the read (old data on a same-address collision)
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hw/rtl/hbi_front.sv */
// ----------------------------------------------------------------------------
// hbi_front
// Input stage: frame size registers, raster counters, weight table lookup.
// ----------------------------------------------------------------------------
module hbi_front
  import hbi_pkg::*;
#(
  parameter int MAX_WIDTH   = 1024,
  parameter int BIN_BITS    = 3,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  input  logic [0:0]                   cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [0:0]                   in_tuser,
  input  logic [IN_TDATA_W-1:0]        in_tdata,
  output logic                         pix_valid,
  input  logic                         pix_ready,
  output pix_flags_t                   pix_flags,
  output logic [$clog2(MAX_WIDTH)-1:0] pix_col,
  output logic [WEIGHT_BITS-1:0]       pix_weight
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int TB = 3 * BIN_BITS;
  localparam int SW = (CW + 1 > CFG_DATA_W) ? CW + 1 : CFG_DATA_W;

  logic [CFG_DATA_W-1:0] frame_width_r;
  logic [CFG_DATA_W-1:0] frame_height_r;
  logic [SW-1:0]         width_ext;
  logic [SW-1:0]         width_cl;
  logic [HEIGHT_W-1:0]   height_cl;
  logic [CW-1:0]         col_r;
  logic [ROW_W-1:0]      row_r;
  logic [SW-1:0]         col_inc;
  logic [HEIGHT_W-1:0]   row_inc;
  logic                  wrap_col;
  logic                  wrap_row;
  logic                  last_pix;

  logic                  in_acc;
  logic                  pix_acc;
  logic                  wt_wr;
  func_t                 func;
  logic [7:0]            chan_a;
  logic [7:0]            chan_b;
  logic [7:0]            chan_c;
  logic [8:0]            bin_index;
  logic [IN_WEIGHT_W-1:0] bin_weight;
  logic [23:0]           weight_wide;
  logic [TB+8:0]         bin_ext;
  logic [TB-1:0]         wr_bin;
  logic [TB-1:0]         rd_bin;

  logic                  s1_valid_r;
  pix_flags_t            s1_flags_r;
  logic [CW-1:0]         s1_col_r;

  // Unpack the input transaction
  assign func       = func_t'(in_tuser[0]);
  assign chan_a     = in_tdata[7:0];
  assign chan_b     = in_tdata[15:8];
  assign chan_c     = in_tdata[23:16];
  assign bin_index  = in_tdata[32:24];
  assign bin_weight = in_tdata[48:33];

  assign in_acc    = in_tvalid && in_tready;
  assign pix_acc   = in_acc && (func == FUNC_PIXEL);
  assign wt_wr     = in_acc && (func == FUNC_WEIGHT);
  assign in_tready = !s1_valid_r || pix_ready;

  // Frame size registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= RST_FRAME_WIDTH;
      frame_height_r <= RST_FRAME_HEIGHT;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the frame size to its legal range
  always_comb begin
    width_ext = SW'(frame_width_r);
    width_cl  = width_ext;
    if (width_ext == '0) begin
      width_cl = SW'(1);
    end else if (width_ext > SW'(MAX_WIDTH)) begin
      width_cl = SW'(MAX_WIDTH);
    end
    height_cl = frame_height_r;
    if (frame_height_r == '0) begin
      height_cl = HEIGHT_W'(1);
    end else if (frame_height_r > HEIGHT_W'(MAX_HEIGHT)) begin
      height_cl = HEIGHT_W'(MAX_HEIGHT);
    end
  end

  // Raster position of the pixel being accepted
  assign col_inc  = SW'(col_r) + SW'(1);
  assign row_inc  = HEIGHT_W'(row_r) + HEIGHT_W'(1);
  assign wrap_col = col_inc >= width_cl;
  assign wrap_row = row_inc >= height_cl;
  assign last_pix = (SW'(col_r) == width_cl - SW'(1)) &&
                    (HEIGHT_W'(row_r) == height_cl - HEIGHT_W'(1));

  // Advance the counters on every accepted pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (pix_acc) begin
      if (wrap_col) begin
        col_r <= '0;
        row_r <= wrap_row ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_r <= col_inc[CW-1:0];
      end
    end
  end

  // Hold the pixel in stage 1 while the weight is read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (pix_acc) begin
      s1_valid_r <= 1'b1;
    end else if (pix_ready) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      s1_flags_r.first_col <= (col_r == '0);
      s1_flags_r.first_row <= (row_r == '0);
      s1_flags_r.frame_end <= last_pix;
      s1_col_r             <= col_r;
    end
  end

  // Weight table addressing and data
  assign weight_wide = 24'($signed(bin_weight));
  assign bin_ext     = {{TB{1'b0}}, bin_index};
  assign wr_bin      = bin_ext[TB-1:0];
  assign rd_bin      = {chan_a[7 -: BIN_BITS], chan_b[7 -: BIN_BITS], chan_c[7 -: BIN_BITS]};

  hbi_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (1 << TB)
  ) u_weight_ram (
    .clk     (clk),
    .wr_en   (wt_wr),
    .wr_addr (wr_bin),
    .wr_data (weight_wide[WEIGHT_BITS-1:0]),
    .rd_en   (pix_acc),
    .rd_addr (rd_bin),
    .rd_data (pix_weight)
  );

  assign pix_valid = s1_valid_r;
  assign pix_flags = s1_flags_r;
  assign pix_col   = s1_col_r;

endmodule

/* hw/rtl/hbi_accum.sv */
// ----------------------------------------------------------------------------
// hbi_accum
// Row running total, line store of the previous row and the result register.
// ----------------------------------------------------------------------------
module hbi_accum
  import hbi_pkg::*;
#(
  parameter int MAX_WIDTH   = 1024,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         pix_valid,
  output logic                         pix_ready,
  input  pix_flags_t                   pix_flags,
  input  logic [$clog2(MAX_WIDTH)-1:0] pix_col,
  input  logic [WEIGHT_BITS-1:0]       pix_weight,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [OUT_TDATA_W-1:0]       out_tdata,
  output logic                         out_tlast
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic              s1_mv;
  logic              s2_mv;
  logic [SUM_W-1:0]  weight_sum;
  logic [SUM_W-1:0]  rt_r;
  logic [SUM_W-1:0]  rt_nxt;

  logic              s2_valid_r;
  logic [CW-1:0]     s2_col_r;
  logic              s2_first_row_r;
  logic              s2_pos_r;
  logic              s2_end_r;
  logic              s2_fwd_r;

  logic [CW-1:0]     last_col_r;
  logic [SUM_W-1:0]  last_tot_r;
  logic [SUM_W-1:0]  line_rd;
  logic [SUM_W-1:0]  prev;
  logic [SUM_W-1:0]  total;

  logic              out_valid_r;
  logic [SUM_W-1:0]  out_sum_r;
  logic [MASK_W-1:0] out_mask_r;
  logic              out_last_r;

  // Stage handshakes
  assign s2_mv     = s2_valid_r && (!out_valid_r || out_tready);
  assign pix_ready = !s2_valid_r || s2_mv;
  assign s1_mv     = pix_valid && pix_ready;

  // Running total of the current row
  assign weight_sum = {{(SUM_W - WEIGHT_BITS){pix_weight[WEIGHT_BITS-1]}}, pix_weight};
  assign rt_nxt     = (pix_flags.first_col ? '0 : rt_r) + weight_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rt_r <= '0;
    end else if (s1_mv) begin
      rt_r <= rt_nxt;
    end
  end

  // Stage 2 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s1_mv) begin
      s2_valid_r <= 1'b1;
    end else if (s2_mv) begin
      s2_valid_r <= 1'b0;
    end
  end

  // Stage 2 payload; note whether the predecessor wrote the line store
  // on the same edge as this pixel's read
  always_ff @(posedge clk) begin
    if (s1_mv) begin
      s2_col_r       <= pix_col;
      s2_first_row_r <= pix_flags.first_row;
      s2_end_r       <= pix_flags.frame_end;
      s2_pos_r       <= (pix_weight != '0) && !pix_weight[WEIGHT_BITS-1];
      s2_fwd_r       <= s2_mv;
    end
  end

  // Bypass the line store when its read missed the predecessor's write
  assign prev  = (s2_fwd_r && (last_col_r == s2_col_r)) ? last_tot_r : line_rd;
  assign total = rt_r + (s2_first_row_r ? '0 : prev);

  always_ff @(posedge clk) begin
    if (s2_mv) begin
      last_col_r <= s2_col_r;
      last_tot_r <= total;
    end
  end

  hbi_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (s2_mv),
    .wr_addr (s2_col_r),
    .wr_data (total),
    .rd_en   (s1_mv),
    .rd_addr (pix_col),
    .rd_data (line_rd)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_mv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_mv) begin
      out_sum_r  <= total;
      out_mask_r <= s2_pos_r ? MASK_ON : MASK_OFF;
      out_last_r <= s2_end_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_mask_r, out_sum_r};
  assign out_tlast  = out_last_r;

endmodule

/* hw/rtl/histogram_backproject_integral.sv */
// ----------------------------------------------------------------------------
// histogram_backproject_integral
// Colour histogram back-projection of a pixel stream with an integral image
// of the per-pixel weights and a positive-weight mask.
//
//   channel | direction | fields
//   --------+-----------+------------------------------------------------------
//   in_     | slave     | tuser: func; tdata: chan_a, chan_b, chan_c,
//           |           |   bin_index, bin_weight
//   out_    | master    | tdata: integral_sum, mask_byte; tlast: frame_end
//   cfg_    | slave     | cfg_index, cfg_data (frame_width, frame_height)
//
// One transaction per cycle on either side while out_tready is high; each
// pixel's result goes through the weight table read at the edge that accepts
// it, then the row add, then the column add into the result register.
// Table writes give no result.
// Reset is synchronous; the weight table and line store are not cleared.
// With out_tready low the result holds; up to three pixels queue before
// in_tready drops.
// ----------------------------------------------------------------------------
module histogram_backproject_integral
  import hbi_pkg::*;
#(
  parameter int MAX_WIDTH   = 1024,
  parameter int BIN_BITS    = 3,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // tuser: func
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [0:0]             in_tuser,
  // tdata: chan_a[7:0], chan_b[15:8], chan_c[23:16], bin_index[32:24],
  //        bin_weight[48:33], zero fill
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // tdata: integral_sum[35:0], mask_byte[43:36], zero fill
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [0:0]             cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic                         pix_valid;
  logic                         pix_ready;
  pix_flags_t                   pix_flags;
  logic [$clog2(MAX_WIDTH)-1:0] pix_col;
  logic [WEIGHT_BITS-1:0]       pix_weight;

  // Registers are always writable
  assign cfg_ready = 1'b1;

  hbi_front #(
    .MAX_WIDTH   (MAX_WIDTH),
    .BIN_BITS    (BIN_BITS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .pix_valid  (pix_valid),
    .pix_ready  (pix_ready),
    .pix_flags  (pix_flags),
    .pix_col    (pix_col),
    .pix_weight (pix_weight)
  );

  hbi_accum #(
    .MAX_WIDTH   (MAX_WIDTH),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .pix_valid  (pix_valid),
    .pix_ready  (pix_ready),
    .pix_flags  (pix_flags),
    .pix_col    (pix_col),
    .pix_weight (pix_weight),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

/* hw/rtl/hbi_checker.sv */
// ----------------------------------------------------------------------------
// hbi_checker
// Port-level checks of the histogram back-projection integral block.
// ----------------------------------------------------------------------------
`include "histogram_backproject_integral_assert.svh"

module hbi_checker
  import hbi_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast
);

  // A stalled result stays offered
  `HBI_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "out_tvalid dropped while stalled")

  // A stalled result keeps its payload
  `HBI_ASSERT(a_out_stable, out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast), "result changed while stalled")

  // Mask byte is all ones or all zeros, fill bits are zero
  `HBI_ASSERT(a_mask_code, out_tvalid |-> (out_tdata[SUM_W+MASK_W-1:SUM_W] == MASK_ON || out_tdata[SUM_W+MASK_W-1:SUM_W] == MASK_OFF) && out_tdata[OUT_TDATA_W-1:SUM_W+MASK_W] == '0, "bad mask byte or fill")

  // No result right after a reset edge
  `HBI_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_tvalid, "result offered out of reset")

endmodule

bind histogram_backproject_integral hbi_checker u_hbi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
